FILE: rtl/i2cebm_pkg.sv
// Package: shared types and constants for the I2C memory byte master.
`default_nettype none
package i2cebm_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DEV_W    = 7;
    localparam int unsigned BITCNT_W = 4;

    // Acknowledge poll limit in ticks of high SDA
    localparam logic [BYTE_W-1:0] ACK_WAIT = 8'd255;
    localparam logic [DEV_W-1:0]  DEV_ADDR_RST = 7'd80;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START_A  = 5'd1,
        PH_START_B  = 5'd2,
        PH_START_C  = 5'd3,
        PH_W_LOW    = 5'd4,
        PH_W_DATA   = 5'd5,
        PH_W_HIGH   = 5'd6,
        PH_W_TLOW   = 5'd7,
        PH_W_TREL   = 5'd8,
        PH_ACK_HIGH = 5'd9,
        PH_ACK_POLL = 5'd10,
        PH_R_LOW    = 5'd11,
        PH_R_REL    = 5'd12,
        PH_R_HIGH   = 5'd13,
        PH_R_FALL   = 5'd14,
        PH_STOP_A   = 5'd15,
        PH_STOP_B   = 5'd16,
        PH_STOP_C   = 5'd17
    } t_phase;

    // Which byte of the transaction is on the wire
    typedef enum logic [1:0] {
        STG_CTRL_W = 2'd0,
        STG_ADDR   = 2'd1,
        STG_DATA   = 2'd2,
        STG_CTRL_R = 2'd3
    } t_stage;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

endpackage : i2cebm_pkg
`default_nettype wire

FILE: rtl/i2c_eeprom_byte_master.sv
// Top level: bit-level I2C master doing one byte write or one random byte read per command.
// An accepted tick beat's result is in the output register in the next cycle.
// Throughput: one tick beat per cycle when o_ready is high; the phase sequencer updates
// once per accepted beat. A held result beat taken the same cycle does not block input.
// Reset (i_rst_n low, synchronous): phase idle, both lines released high, received byte
// cleared, device address back to its default, output register empty.
`default_nettype none
module i2c_eeprom_byte_master
    import i2cebm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [DEV_W-1:0]    i_cfg_data,
    // tick input channel
    input  wire logic                i_valid,
    output      logic                o_ready,
    input  wire logic                i_cmd_valid,
    input  wire logic                i_opcode,
    input  wire logic [BYTE_W-1:0]   i_mem_address,
    input  wire logic [BYTE_W-1:0]   i_write_data,
    input  wire logic                i_sda_in,
    // result channel
    output      logic                o_valid,
    input  wire logic                i_ready,
    output      logic                o_scl_level,
    output      logic                o_sda_level,
    output      logic                o_busy_res,
    output      logic                o_done_res,
    output      logic [BYTE_W-1:0]   o_read_data
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_phase              r_phase,    n_phase;
    t_stage              r_stage,    n_stage;
    logic [BITCNT_W-1:0] r_bit_cnt,  n_bit_cnt;
    logic [BYTE_W-1:0]   r_shift,    n_shift;
    logic [BYTE_W-1:0]   r_ack_cnt,  n_ack_cnt;
    logic                r_is_read,  n_is_read;
    logic [BYTE_W-1:0]   r_held_addr, n_held_addr;
    logic [BYTE_W-1:0]   r_held_data, n_held_data;
    logic [BYTE_W-1:0]   r_rx_byte,  n_rx_byte;
    logic                r_scl,      n_scl;
    logic                r_sda,      n_sda;
    logic [DEV_W-1:0]    r_dev_addr;

    // result register
    logic                r_out_valid;
    logic                r_res_scl;
    logic                r_res_sda;
    logic                r_res_busy;
    logic                r_res_done;
    logic [BYTE_W-1:0]   r_res_rx;

    logic                n_busy;
    logic                n_done;

    logic                accept;
    logic                ack_end;
    logic                byte_end;
    logic [BITCNT_W-1:0] bit_inc;
    logic [BYTE_W-1:0]   ctrl_byte;

    // Output register frees up whenever it is empty or being drained this cycle.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign bit_inc  = r_bit_cnt + 4'd1;
    assign byte_end = (bit_inc >= BITS_PER_BYTE);

    // Ack poll ends on a low SDA sample or when the high-sample budget runs out.
    assign ack_end = !(i_sda_in && (r_ack_cnt < ACK_WAIT));

    // Control byte: device address with R/W bit; read only on the second start.
    assign ctrl_byte = {r_dev_addr, (r_stage == STG_CTRL_R)};

    // ---------------------------------------------------------------
    // Next phase / stage
    // ---------------------------------------------------------------
    always_comb begin
        n_phase = r_phase;
        n_stage = r_stage;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd_valid) begin
                    // Lines already released: go straight to raising SCL
                    n_phase = PH_START_B;
                    n_stage = STG_CTRL_W;
                end
            end
            PH_START_A:  n_phase = PH_START_B;
            PH_START_B:  n_phase = PH_START_C;
            PH_START_C:  n_phase = PH_W_LOW;
            PH_W_LOW:    n_phase = PH_W_DATA;
            PH_W_DATA:   n_phase = PH_W_HIGH;
            PH_W_HIGH:   n_phase = byte_end ? PH_W_TLOW : PH_W_LOW;
            PH_W_TLOW:   n_phase = PH_W_TREL;
            PH_W_TREL:   n_phase = PH_ACK_HIGH;
            PH_ACK_HIGH: n_phase = PH_ACK_POLL;
            PH_ACK_POLL: begin
                if (ack_end) begin
                    unique case (r_stage)
                        STG_CTRL_W: begin
                            n_stage = STG_ADDR;
                            n_phase = PH_W_LOW;
                        end
                        STG_ADDR: begin
                            if (r_is_read) begin
                                // random read: repeated start then read control byte
                                n_stage = STG_CTRL_R;
                                n_phase = PH_START_A;
                            end else begin
                                n_stage = STG_DATA;
                                n_phase = PH_W_LOW;
                            end
                        end
                        STG_CTRL_R: n_phase = PH_R_LOW;
                        STG_DATA:   n_phase = PH_STOP_A;
                    endcase
                end
            end
            PH_R_LOW:    n_phase = PH_R_REL;
            PH_R_REL:    n_phase = PH_R_HIGH;
            PH_R_HIGH:   n_phase = PH_R_FALL;
            PH_R_FALL:   n_phase = byte_end ? PH_STOP_A : PH_R_HIGH;
            PH_STOP_A:   n_phase = PH_STOP_B;
            PH_STOP_B:   n_phase = PH_STOP_C;
            PH_STOP_C:   n_phase = PH_IDLE;
            default:     n_phase = PH_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Line levels, shifter, counters and result flags
    // ---------------------------------------------------------------
    always_comb begin
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_ack_cnt   = r_ack_cnt;
        n_is_read   = r_is_read;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_rx_byte   = r_rx_byte;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_busy      = (r_phase != PH_IDLE);
        n_done      = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd_valid) begin
                    n_busy      = 1'b1;
                    n_is_read   = (i_opcode == OP_READ);
                    n_held_addr = i_mem_address;
                    n_held_data = i_write_data;
                    n_sda       = 1'b1;
                end
            end
            PH_START_A: n_sda = 1'b1;
            PH_START_B: n_scl = 1'b1;
            PH_START_C: begin
                // SDA falls with SCL high: (repeated) start
                n_sda     = 1'b0;
                n_shift   = ctrl_byte;
                n_bit_cnt = '0;
            end
            PH_W_LOW: n_scl = 1'b0;
            PH_W_DATA: begin
                n_sda   = r_shift[BYTE_W-1];
                n_shift = {r_shift[BYTE_W-2:0], 1'b0};
            end
            PH_W_HIGH: begin
                n_scl     = 1'b1;
                n_bit_cnt = byte_end ? '0 : bit_inc;
            end
            PH_W_TLOW: n_scl = 1'b0;
            PH_W_TREL: n_sda = 1'b1;
            PH_ACK_HIGH: begin
                n_scl     = 1'b1;
                n_ack_cnt = '0;
            end
            PH_ACK_POLL: begin
                if (!ack_end) begin
                    n_ack_cnt = r_ack_cnt + 8'd1;
                end else begin
                    n_scl = 1'b0;
                    unique case (r_stage)
                        STG_CTRL_W: begin
                            n_shift   = r_held_addr;
                            n_bit_cnt = '0;
                        end
                        STG_ADDR: begin
                            if (!r_is_read) begin
                                n_shift   = r_held_data;
                                n_bit_cnt = '0;
                            end
                        end
                        STG_CTRL_R: n_bit_cnt = '0;
                        STG_DATA:   ;
                    endcase
                end
            end
            PH_R_LOW: n_scl = 1'b0;
            PH_R_REL: begin
                n_sda     = 1'b1;
                n_bit_cnt = '0;
            end
            PH_R_HIGH: begin
                n_scl   = 1'b1;
                n_shift = {r_shift[BYTE_W-2:0], i_sda_in};
            end
            PH_R_FALL: begin
                n_scl = 1'b0;
                if (byte_end) begin
                    n_bit_cnt = '0;
                    n_rx_byte = r_shift;
                end else begin
                    n_bit_cnt = bit_inc;
                end
            end
            PH_STOP_A: n_sda = 1'b0;
            PH_STOP_B: n_scl = 1'b1;
            PH_STOP_C: begin
                // SDA rises with SCL high: stop
                n_sda  = 1'b1;
                n_done = 1'b1;
            end
            default: begin
                n_scl  = 1'b1;
                n_sda  = 1'b1;
                n_busy = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_stage     <= STG_CTRL_W;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_ack_cnt   <= '0;
            r_is_read   <= 1'b0;
            r_held_addr <= '0;
            r_held_data <= '0;
            r_rx_byte   <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_stage     <= n_stage;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_ack_cnt   <= n_ack_cnt;
            r_is_read   <= n_is_read;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_rx_byte   <= n_rx_byte;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_scl  <= n_scl;
            r_res_sda  <= n_sda;
            r_res_busy <= n_busy;
            r_res_done <= n_done;
            r_res_rx   <= n_rx_byte;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl_level = r_res_scl;
    assign o_sda_level = r_res_sda;
    assign o_busy_res  = r_res_busy;
    assign o_done_res  = r_res_done;
    assign o_read_data = r_res_rx;

`ifndef SYNTHESIS
    // A stop-complete beat always belongs to a transaction.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_done) |-> r_res_busy)
        else $error("done beat without busy");

    // SCL is held high for the whole acknowledge poll.
    a_poll_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ACK_POLL) |-> r_scl)
        else $error("SCL low during ack poll");

    // The poll counter never passes its limit.
    a_ack_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ack_cnt <= ACK_WAIT)
        else $error("ack wait counter overran");

    // A command taken while idle starts the start sequence at the SCL-high step.
    a_cmd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_phase == PH_IDLE) && i_cmd_valid) |=> (r_phase == PH_START_B))
        else $error("command did not launch start condition");
`endif

endmodule : i2c_eeprom_byte_master
`default_nettype wire
